>>> design/tsevt_pkg.sv
// Shared types and codes for the time sorted event table.
package tsevt_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int CTL_W = 7;   // wide enough for any fill count or cell index up to 64
    localparam int MAX_READ = 16;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;   // {year, month, day, hour, minute}
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [4:0]       del_pos;
        logic [CTL_W-1:0] count;
        t_entry           new_entry;
    } t_cell_ctl;

endpackage

>>> design/tsevt_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module tsevt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  tsevt_pkg::t_cell_ctl i_ctl,
    input  tsevt_pkg::t_entry    i_left,
    input  logic                 i_left_move,
    input  tsevt_pkg::t_entry    i_right,
    output tsevt_pkg::t_entry    o_entry,
    output logic                 o_move
);

    tsevt_pkg::t_entry r_entry;
    tsevt_pkg::t_entry n_entry;

    // This slot lies at or after the insertion point: empty, or later than the new key.
    assign o_move = (tsevt_pkg::CTL_W'(CELL_IDX) >= i_ctl.count) ||
                    (r_entry.key > i_ctl.new_entry.key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_move) begin
                n_entry = i_left;
            end else if (o_move) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.del &&
                     (tsevt_pkg::CTL_W'(CELL_IDX + 1) >= tsevt_pkg::CTL_W'(i_ctl.del_pos))) begin
            // close the gap: pull from the right
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> design/time_sorted_event_table.sv
// Top level of the time sorted event table: control, cell chain and result register.
// On an add or delete every cell compares and shifts at the accepting edge,
// and the single result is registered at that same edge.
// A read of n entries emits one entry per cycle while the output is free, from an indexed
// pick over the chain; no new transaction is accepted until the last entry is emitted.
// Synchronous active-low reset empties the table (fill count 0) and drops the output valid.
module time_sorted_event_table #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // year, month, day, hour, minute, payload_tag,
                                     // position, read_limit, zero fill
    input  logic [1:0]  i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // entry_year, entry_month, entry_day, entry_hour,
                                     // entry_minute, entry_tag, entry_position,
                                     // entry_count, zero fill
    output logic [2:0]  o_m_tuser,   // status, entry_valid
    output logic        o_m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_rd_num, n_rd_num;

    logic        r_ov, n_ov;
    logic [1:0]  r_o_status, n_o_status;
    logic        r_o_evalid, n_o_evalid;
    tsevt_pkg::t_entry r_o_entry, n_o_entry;
    logic [4:0]  r_o_pos, n_o_pos;
    logic [4:0]  r_o_count, n_o_count;
    logic        r_o_last, n_o_last;

    tsevt_pkg::t_cell_ctl w_ctl;
    tsevt_pkg::t_entry    w_entry [DEPTH];
    logic                 w_move  [DEPTH];

    logic        w_out_free, w_accept, w_full, w_pos_ok;
    logic [1:0]  w_op;
    logic [4:0]  w_pos, w_lim, w_lim_sat;
    logic [tsevt_pkg::CTL_W-1:0] w_cnt_x, w_n_x;
    logic [tsevt_pkg::CTL_W-1:0] w_min;

    assign w_out_free = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_op    = i_s_tuser;
    assign w_pos   = i_s_tdata[52:48];
    assign w_lim   = i_s_tdata[57:53];
    assign w_cnt_x = tsevt_pkg::CTL_W'(r_count);
    assign w_full  = (w_cnt_x >= tsevt_pkg::CTL_W'(DEPTH));
    assign w_pos_ok = (w_pos != 5'd0) && (tsevt_pkg::CTL_W'(w_pos) <= w_cnt_x);
    assign w_lim_sat = (w_lim > 5'(tsevt_pkg::MAX_READ)) ? 5'(tsevt_pkg::MAX_READ) : w_lim;
    assign w_min = (w_cnt_x < tsevt_pkg::CTL_W'(w_lim_sat)) ? w_cnt_x
                                                          : tsevt_pkg::CTL_W'(w_lim_sat);

    always_comb begin
        w_ctl.ins     = w_accept && (w_op == tsevt_pkg::OP_ADD) && !w_full;
        w_ctl.del     = w_accept && (w_op == tsevt_pkg::OP_DEL) && w_pos_ok;
        w_ctl.del_pos = w_pos;
        w_ctl.count   = w_cnt_x;
        w_ctl.new_entry.key = {i_s_tdata[11:0], i_s_tdata[15:12], i_s_tdata[20:16],
                               i_s_tdata[25:21], i_s_tdata[31:26]};
        w_ctl.new_entry.tag = i_s_tdata[47:32];
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tsevt_pkg::t_entry w_left, w_right;
        logic              w_left_move;
        if (g == 0) begin : g_head
            assign w_left      = w_ctl.new_entry;
            assign w_left_move = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_move = w_move[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end
        tsevt_cell #(.CELL_IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_left_move (w_left_move),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_move      (w_move[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_rd_num   = r_rd_num;
        n_ov       = r_ov && !i_m_tready;
        n_o_status = r_o_status;
        n_o_evalid = r_o_evalid;
        n_o_entry  = r_o_entry;
        n_o_pos    = r_o_pos;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        w_n_x      = w_cnt_x;

        if (w_accept) begin
            n_ov       = 1'b1;
            n_o_evalid = 1'b0;
            n_o_entry  = '0;
            n_o_pos    = 5'd0;
            n_o_last   = 1'b1;
            n_o_status = tsevt_pkg::ST_OK;
            unique case (w_op)
                tsevt_pkg::OP_ADD: begin
                    if (w_full) begin
                        n_o_status = tsevt_pkg::ST_FULL;
                    end else begin
                        w_n_x = w_cnt_x + 1'b1;
                    end
                end
                tsevt_pkg::OP_DEL: begin
                    if (w_pos_ok) begin
                        w_n_x = w_cnt_x - 1'b1;
                    end else begin
                        n_o_status = tsevt_pkg::ST_BAD;
                    end
                end
                tsevt_pkg::OP_READ: begin
                    if (w_lim == 5'd0) begin
                        n_o_status = tsevt_pkg::ST_BAD;
                    end else if (w_min != '0) begin
                        // hand the run to the read state instead
                        n_ov     = 1'b0;
                        n_state  = S_READ;
                        n_rd_idx = '0;
                        n_rd_num = CW'(w_min);
                    end
                end
                default: begin
                    n_o_status = tsevt_pkg::ST_BAD;
                end
            endcase
            n_count   = CW'(w_n_x);
            n_o_count = w_n_x[4:0];
        end else if ((r_state == S_READ) && w_out_free) begin
            n_ov       = 1'b1;
            n_o_status = tsevt_pkg::ST_OK;
            n_o_evalid = 1'b1;
            n_o_entry  = w_entry[r_rd_idx];
            n_o_pos    = 5'(tsevt_pkg::CTL_W'(r_rd_idx) + 1'b1);
            n_o_count  = w_cnt_x[4:0];
            n_o_last   = (CW'(r_rd_idx) + 1'b1 == r_rd_num);
            if (n_o_last) begin
                n_state = S_IDLE;
            end else begin
                n_rd_idx = r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_rd_num <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_rd_num <= n_rd_num;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status <= n_o_status;
        r_o_evalid <= n_o_evalid;
        r_o_entry  <= n_o_entry;
        r_o_pos    <= n_o_pos;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = {r_o_evalid, r_o_status};
    assign o_m_tdata  = {6'd0, r_o_count, r_o_pos, r_o_entry.tag,
                         r_o_entry.key[5:0], r_o_entry.key[10:6], r_o_entry.key[15:11],
                         r_o_entry.key[19:16], r_o_entry.key[31:20]};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tsevt_pkg::CTL_W'(r_count) <= tsevt_pkg::CTL_W'(DEPTH))
        else $error("fill count above depth");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rd_num != '0) && (CW'(r_rd_idx) < r_rd_num))
        else $error("read run index out of range");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("add did not grow the table");

    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the table");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_s_tready)
        else $error("transaction taken during a read run");

endmodule
